// File: sv/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// next-cycle implication, checked outside reset
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

// File: sv/mme_pkg.sv
// shared types and codes of the matrix multiply engine
package mme_pkg;

	// request commands
	localparam logic [1:0] CMD_LOAD_A = 2'd0;
	localparam logic [1:0] CMD_LOAD_B = 2'd1;
	localparam logic [1:0] CMD_RUN    = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_N = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_K  = 2'd2;

	// result and element field widths
	localparam int ACC_W = 36;
	localparam int OUT_IDX_W = 3;
	localparam int ELEM_W = 16;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

	// one product term issued by the sequencer
	typedef struct packed {
		logic                 valid;
		logic                 zero;
		logic                 first;
		logic                 dot_last;
		logic                 run_last;
		logic [OUT_IDX_W-1:0] row;
		logic [OUT_IDX_W-1:0] col;
	} term_t;

endpackage

// File: sv/matrix_multiply_engine.sv
// top level of the matrix multiply engine
// Usage:
// Input channel (in_valid / in_stall) takes one request per cycle while no
// run is in progress: load A, load B (one element at row_index, col_index)
// or run. Loads beyond the store size and unused commands are dropped.
// A run computes C = A x B over the configured sizes and returns one result
// per C element in row-major order on the output channel (out_valid /
// out_stall); last_element marks the final one. in_stall is high while the
// sequencer walks the run, one multiply-accumulate per cycle unless the
// output stalls. A single MAC does the work, reading each store once per
// cycle unless the output stalls.
// A stalled output holds its result and freezes the whole MAC pipe until
// it is taken. Reset sets each size to 8 (the store size at the default
// MAX_DIM) and empties the pipe; store contents are undefined until loaded.
// The user must write sizes on the cfg port only while the block is idle;
// the block does not enforce this.
`include "assert_macros.svh"

module matrix_multiply_engine #(
	parameter int MAX_DIM = 8,
	parameter int DATA_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mme_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  row_index,
	input  logic [2:0]  col_index,
	input  logic signed [mme_pkg::ELEM_W-1:0] element_value,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic signed [mme_pkg::ACC_W-1:0] product_value,
	output logic [mme_pkg::OUT_IDX_W-1:0] out_row,
	output logic [mme_pkg::OUT_IDX_W-1:0] out_col,
	output logic        last_element
);

	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = MAX_DIM > 1 ? $clog2(DEPTH) : 1;

	logic [mme_pkg::CFG_DATA_W-1:0] rows_m_q, inner_n_q, cols_k_q;
	logic [CNT_W-1:0] m_eff, n_eff, k_eff;
	logic in_accept, run_start, load_ok, a_we, b_we, adv;
	logic [ADDR_W-1:0] waddr, a_raddr, b_raddr;
	logic [DATA_WIDTH-1:0] wdata, a_data, b_data;
	mme_pkg::term_t term;

	// sizes above the store size act as the store size
	function automatic logic [CNT_W-1:0] clamp_dim(input logic [mme_pkg::CFG_DATA_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (32'(v) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= mme_pkg::CFG_DATA_W'(8);
			inner_n_q <= mme_pkg::CFG_DATA_W'(8);
			cols_k_q  <= mme_pkg::CFG_DATA_W'(8);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mme_pkg::REG_ROWS_M:  rows_m_q  <= cfg_data;
				mme_pkg::REG_INNER_N: inner_n_q <= cfg_data;
				mme_pkg::REG_COLS_K:  cols_k_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign m_eff = clamp_dim(rows_m_q);
	assign n_eff = clamp_dim(inner_n_q);
	assign k_eff = clamp_dim(cols_k_q);

	// request decode
	always_comb begin
		in_accept = in_valid && !in_stall;
		run_start = in_accept && (command == mme_pkg::CMD_RUN);
		load_ok   = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
		a_we      = in_accept && load_ok && (command == mme_pkg::CMD_LOAD_A);
		b_we      = in_accept && load_ok && (command == mme_pkg::CMD_LOAD_B);
		waddr     = ADDR_W'(32'(row_index) * MAX_DIM + 32'(col_index));
		wdata     = DATA_WIDTH'($unsigned(element_value));
	end

	mme_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (adv),
		.raddr (a_raddr),
		.rdata (a_data)
	);

	mme_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (adv),
		.raddr (b_raddr),
		.rdata (b_data)
	);

	mme_seq #(
		.MAX_DIM(MAX_DIM)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (run_start),
		.m_eff   (m_eff),
		.n_eff   (n_eff),
		.k_eff   (k_eff),
		.adv     (adv),
		.busy    (in_stall),
		.a_raddr (a_raddr),
		.b_raddr (b_raddr),
		.term    (term)
	);

	mme_mac #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.term          (term),
		.a_data        (a_data),
		.b_data        (b_data),
		.adv           (adv),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.product_value (product_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.last_element  (last_element)
	);

	// a run with rows and columns in use locks out requests next cycle
	`MME_ASSERT_NEXT(a_run_locks, clk, arst_n, run_start && (m_eff != '0) && (k_eff != '0), in_stall)
	// an empty run leaves the request channel open
	`MME_ASSERT_NEXT(a_empty_run, clk, arst_n, run_start && ((m_eff == '0) || (k_eff == '0)), !in_stall)
	// a run only ends on a cycle in which the pipe moved
	`MME_ASSERT_NOW(a_run_end_adv, clk, arst_n, $fell(in_stall), $past(adv))

endmodule

// File: sv/mme_ram.sv
// generic single-port-write ram with registered read
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/mme_seq.sv
// run sequencer: walks rows, columns and dot terms and issues store reads
module mme_seq #(
	parameter int MAX_DIM = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [$clog2(MAX_DIM+1)-1:0] m_eff,
	input  logic [$clog2(MAX_DIM+1)-1:0] n_eff,
	input  logic [$clog2(MAX_DIM+1)-1:0] k_eff,
	input  logic                  adv,
	output logic                  busy,
	output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] a_raddr,
	output logic [(MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] b_raddr,
	output mme_pkg::term_t        term
);

	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int IDX_W = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = MAX_DIM > 1 ? $clog2(MAX_DIM * MAX_DIM) : 1;

	mme_pkg::seq_state_t state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q, t_q;
	logic term_last, col_last, row_last, n_zero;

	// loop end conditions
	always_comb begin
		n_zero    = (n_eff == '0);
		term_last = n_zero || ((CNT_W'(t_q) + CNT_W'(1)) == n_eff);
		col_last  = (CNT_W'(j_q) + CNT_W'(1)) == k_eff;
		row_last  = (CNT_W'(i_q) + CNT_W'(1)) == m_eff;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				if (start && (m_eff != '0) && (k_eff != '0)) begin
					state_d = mme_pkg::ST_RUN;
				end
			end
			mme_pkg::ST_RUN: begin
				if (adv && term_last && col_last && row_last) begin
					state_d = mme_pkg::ST_IDLE;
				end
			end
			default: state_d = mme_pkg::ST_IDLE;
		endcase
	end

	// outputs: issued term and store addresses
	always_comb begin
		busy          = (state_q == mme_pkg::ST_RUN);
		term.valid    = busy;
		term.zero     = n_zero;
		term.first    = (t_q == '0);
		term.dot_last = term_last;
		term.run_last = term_last && col_last && row_last;
		term.row      = mme_pkg::OUT_IDX_W'(i_q);
		term.col      = mme_pkg::OUT_IDX_W'(j_q);
		a_raddr       = ADDR_W'(32'(i_q) * MAX_DIM + 32'(t_q));
		b_raddr       = ADDR_W'(32'(t_q) * MAX_DIM + 32'(j_q));
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			t_q <= '0;
		end else if (state_q == mme_pkg::ST_IDLE) begin
			i_q <= '0;
			j_q <= '0;
			t_q <= '0;
		end else if (adv) begin
			if (!term_last) begin
				t_q <= t_q + IDX_W'(1);
			end else begin
				t_q <= '0;
				if (!col_last) begin
					j_q <= j_q + IDX_W'(1);
				end else begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

// File: sv/mme_mac.sv
// multiply-accumulate datapath with result output register
module mme_mac #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mme_pkg::term_t        term,
	input  logic [DATA_WIDTH-1:0] a_data,
	input  logic [DATA_WIDTH-1:0] b_data,
	output logic                  adv,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [mme_pkg::ACC_W-1:0] product_value,
	output logic [mme_pkg::OUT_IDX_W-1:0] out_row,
	output logic [mme_pkg::OUT_IDX_W-1:0] out_col,
	output logic                  last_element
);

	localparam int PROD_W = 2 * DATA_WIDTH;

	mme_pkg::term_t tag_s1, tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [mme_pkg::ACC_W-1:0] acc_q, acc_sum;
	logic res_valid_q;
	logic signed [mme_pkg::ACC_W-1:0] product_q;
	logic [mme_pkg::OUT_IDX_W-1:0] row_q, col_q;
	logic last_q;

	// the whole pipe moves when the output register is free or being taken
	assign adv = !res_valid_q || !out_stall;

	// running sum, restarted on the first term of each dot product
	assign acc_sum = (tag_s2.first ? '0 : acc_q) + mme_pkg::ACC_W'(prod_s2);

	// term tags follow the store read and the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s1 <= term;
			tag_s2 <= tag_s1;
		end
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (adv) begin
			if (tag_s1.zero) begin
				prod_s2 <= '0;
			end else begin
				prod_s2 <= $signed(a_data) * $signed(b_data);
			end
		end
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && tag_s2.valid) begin
			acc_q <= acc_sum;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= tag_s2.valid && tag_s2.dot_last;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && tag_s2.valid && tag_s2.dot_last) begin
			product_q <= acc_sum;
			row_q     <= tag_s2.row;
			col_q     <= tag_s2.col;
			last_q    <= tag_s2.run_last;
		end
	end

	assign out_valid     = res_valid_q;
	assign product_value = product_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign last_element  = last_q;

endmodule
